FILE: rtl/length_prefix_deframer_unit_defines.svh
// Assertion macros for the length-prefix deframer.
`ifndef LENGTH_PREFIX_DEFRAMER_UNIT_DEFINES_SVH
`define LENGTH_PREFIX_DEFRAMER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define LPD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("deframer assertion failed");
`define LPD_ASSERT_IMPL(lbl, ante, cons) \
	`LPD_ASSERT(lbl, (ante) |-> (cons))
`else
`define LPD_ASSERT(lbl, prop)
`define LPD_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

FILE: rtl/lpd_pkg.sv
// Package with the phase codes and result type of the length-prefix deframer.
`timescale 1ns / 1ps
package lpd_pkg;
	localparam int PHASE_W = 2;
	localparam logic [PHASE_W-1:0] PHASE_LEN_HI  = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_LEN_LO  = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_PAYLOAD = 2'd2;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 16;

	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic              first_of_message;
		logic              last_of_message;
		logic              empty_message;
		logic [LEN_W-1:0]  message_length;
	} result_t;
endpackage

FILE: rtl/length_prefix_deframer_unit.sv
// Top level of the two-byte length-prefix deframer for a TCP byte stream.
`timescale 1ns / 1ps
// The block takes one stream word per cycle unless a held output stalls the input. Each message
// starts with a big-endian 16-bit length; for a nonzero length the two length words give no
// result. Every payload word gives one result carrying the byte, the message length, and first
// and last flags; a zero-length message gives a single result with the empty flag when its low
// length word arrives. An accepted word is held in the input register, where the phase and byte
// counters are updated, and its result is then registered in the output register. A held output
// only stalls the input once the input register also holds a word that produces a result.
`include "length_prefix_deframer_unit_defines.svh"
module length_prefix_deframer_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [lpd_pkg::BYTE_W-1:0] stream_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lpd_pkg::BYTE_W-1:0] payload_byte,
	output logic                       first_of_message,
	output logic                       last_of_message,
	output logic                       empty_message,
	output logic [lpd_pkg::LEN_W-1:0]  message_length
);
	import lpd_pkg::*;

	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               valid_s2;
	result_t            result_s2;

	logic [PHASE_W-1:0] phase_q;
	logic [BYTE_W-1:0]  length_high_byte_q;
	logic [LEN_W-1:0]   current_length_q;
	logic [LEN_W-1:0]   bytes_remaining_q;

	logic [PHASE_W-1:0] phase_d;
	logic [BYTE_W-1:0]  length_high_byte_d;
	logic [LEN_W-1:0]   current_length_d;
	logic [LEN_W-1:0]   bytes_remaining_d;
	logic [LEN_W-1:0]   new_length;
	logic               has_result;
	result_t            result_d;
	logic               advance_s1;

	always_comb begin
		phase_d            = phase_q;
		length_high_byte_d = length_high_byte_q;
		current_length_d   = current_length_q;
		bytes_remaining_d  = bytes_remaining_q;
		new_length         = {length_high_byte_q, byte_s1};
		has_result         = 1'b0;
		result_d           = '0;
		unique case (phase_q)
			PHASE_LEN_LO: begin
				current_length_d = new_length;
				bytes_remaining_d = new_length;
				if (new_length == '0) begin
					phase_d = PHASE_LEN_HI;
					has_result = 1'b1;
					result_d.first_of_message = 1'b1;
					result_d.last_of_message = 1'b1;
					result_d.empty_message = 1'b1;
				end else begin
					phase_d = PHASE_PAYLOAD;
				end
			end
			PHASE_PAYLOAD: begin
				if (bytes_remaining_q != '0) begin
					bytes_remaining_d = bytes_remaining_q - LEN_W'(1);
					if (bytes_remaining_q == LEN_W'(1)) begin
						phase_d = PHASE_LEN_HI;
					end
					has_result = 1'b1;
					result_d.payload_byte = byte_s1;
					result_d.first_of_message = (bytes_remaining_q == current_length_q);
					result_d.last_of_message = (bytes_remaining_q == LEN_W'(1));
					result_d.message_length = current_length_q;
				end else begin
					length_high_byte_d = byte_s1;
					phase_d = PHASE_LEN_LO;
				end
			end
			default: begin
				length_high_byte_d = byte_s1;
				phase_d = PHASE_LEN_LO;
			end
		endcase
	end

	// A word leaves the input register unless its result has nowhere to go.
	assign advance_s1 = valid_s1 && (!has_result || !valid_s2 || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= stream_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q            <= PHASE_LEN_HI;
			length_high_byte_q <= '0;
			current_length_q   <= '0;
			bytes_remaining_q  <= '0;
		end else if (advance_s1) begin
			phase_q            <= phase_d;
			length_high_byte_q <= length_high_byte_d;
			current_length_q   <= current_length_d;
			bytes_remaining_q  <= bytes_remaining_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1 && has_result) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && has_result) begin
			result_s2 <= result_d;
		end
	end

	assign out_valid        = valid_s2;
	assign payload_byte     = result_s2.payload_byte;
	assign first_of_message = result_s2.first_of_message;
	assign last_of_message  = result_s2.last_of_message;
	assign empty_message    = result_s2.empty_message;
	assign message_length   = result_s2.message_length;

	`LPD_ASSERT_IMPL(a_payload_iff_remaining, 1'b1, (phase_q == PHASE_PAYLOAD) == (bytes_remaining_q != '0))
	`LPD_ASSERT_IMPL(a_remaining_bounded, phase_q == PHASE_PAYLOAD, bytes_remaining_q <= current_length_q)
	`LPD_ASSERT_IMPL(a_empty_shape, valid_s2 && result_s2.empty_message, result_s2.first_of_message && result_s2.last_of_message && (result_s2.message_length == '0) && (result_s2.payload_byte == '0))
	`LPD_ASSERT_IMPL(a_stall_holds_input, valid_s1 && !advance_s1, ##1 (valid_s1 && $stable(byte_s1)))
endmodule

FILE: tb/length_prefix_deframer_unit_test.sv
// Self-checking testbench for the two-byte length-prefix deframer.
`timescale 1ns / 1ps
module length_prefix_deframer_unit_test;
	import lpd_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DIRECTED_ROWS = 19;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_SILENT,
		ROW_RESULT
	} row_kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] word;
		row_kind_t         kind;
		result_t           want;
	} stim_row_t;

	localparam result_t NO_RESULT = '0;
	localparam result_t EMPTY_MSG = '{8'h00, 1'b1, 1'b1, 1'b1, 16'h0000};
	localparam result_t ONE_FF    = '{8'hFF, 1'b1, 1'b1, 1'b0, 16'h0001};
	localparam result_t ONE_00    = '{8'h00, 1'b1, 1'b1, 1'b0, 16'h0001};

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{8'h00, ROW_SILENT, NO_RESULT},
		'{8'h00, ROW_RESULT, EMPTY_MSG},
		'{8'h00, ROW_SILENT, NO_RESULT},
		'{8'h01, ROW_SILENT, NO_RESULT},
		'{8'hFF, ROW_RESULT, ONE_FF},
		'{8'h00, ROW_SILENT, NO_RESULT},
		'{8'h01, ROW_SILENT, NO_RESULT},
		'{8'h00, ROW_RESULT, ONE_00},
		'{8'h00, ROW_PREDICT, NO_RESULT},
		'{8'h03, ROW_PREDICT, NO_RESULT},
		'{8'h5A, ROW_PREDICT, NO_RESULT},
		'{8'hA5, ROW_PREDICT, NO_RESULT},
		'{8'hC3, ROW_PREDICT, NO_RESULT},
		'{8'h00, ROW_SILENT, NO_RESULT},
		'{8'h00, ROW_RESULT, EMPTY_MSG},
		'{8'h00, ROW_PREDICT, NO_RESULT},
		'{8'h02, ROW_PREDICT, NO_RESULT},
		'{8'h80, ROW_PREDICT, NO_RESULT},
		'{8'h7F, ROW_PREDICT, NO_RESULT}
	};

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] stream_byte = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [BYTE_W-1:0] payload_byte;
	logic              first_of_message;
	logic              last_of_message;
	logic              empty_message;
	logic [LEN_W-1:0]  message_length;

	logic [PHASE_W-1:0] prefix_phase = PHASE_LEN_HI;
	logic [BYTE_W-1:0]  len_hi_seen = '0;
	logic [LEN_W-1:0]   msg_len = '0;
	logic [LEN_W-1:0]   msg_left = '0;

	result_t payload_due[$];
	int      errors = 0;
	int      idle_cycles = 0;
	int      send_idle_pct = 33;
	int      recv_idle_pct = 55;

	length_prefix_deframer_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.stream_byte      (stream_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.payload_byte     (payload_byte),
		.first_of_message (first_of_message),
		.last_of_message  (last_of_message),
		.empty_message    (empty_message),
		.message_length   (message_length)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic deframe_word(input logic [BYTE_W-1:0] b, output result_t r);
		r = '0;
		if (prefix_phase == PHASE_LEN_LO) begin
			msg_len = {len_hi_seen, b};
			if (msg_len == '0) begin
				prefix_phase = PHASE_LEN_HI;
				msg_left = '0;
				r.first_of_message = 1'b1;
				r.last_of_message = 1'b1;
				r.empty_message = 1'b1;
				return 1'b1;
			end
			msg_left = msg_len;
			prefix_phase = PHASE_PAYLOAD;
			return 1'b0;
		end
		if (prefix_phase == PHASE_PAYLOAD && msg_left != '0) begin
			r.payload_byte = b;
			r.first_of_message = (msg_left == msg_len);
			r.last_of_message = (msg_left == 16'd1);
			r.message_length = msg_len;
			msg_left = msg_left - 16'd1;
			if (msg_left == '0)
				prefix_phase = PHASE_LEN_HI;
			return 1'b1;
		end
		len_hi_seen = b;
		prefix_phase = PHASE_LEN_LO;
		return 1'b0;
	endfunction

	task automatic flag_error(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		errors++;
	endtask

	task automatic send_word(input logic [BYTE_W-1:0] b, input row_kind_t kind,
			input result_t want);
		result_t r;
		logic    produces;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (!in_ready);
		produces = deframe_word(b, r);
		if (kind == ROW_RESULT)
			payload_due.push_back(want);
		else if (kind == ROW_PREDICT && produces)
			payload_due.push_back(r);
		@(negedge clk);
	endtask

	task automatic send_message(input logic [LEN_W-1:0] len, input int body);
		send_word(len[15:8], ROW_PREDICT, NO_RESULT);
		send_word(len[7:0], ROW_PREDICT, NO_RESULT);
		repeat (body)
			send_word(BYTE_W'($urandom_range(255)), ROW_PREDICT, NO_RESULT);
	endtask

	task automatic run_traffic(input int items);
		int sent;
		int len;
		int roll;
		sent = 0;
		while (sent < items) begin
			roll = $urandom_range(99);
			if (roll < 15)
				len = 0;
			else if (roll < 75)
				len = $urandom_range(8, 1);
			else if (roll < 95)
				len = $urandom_range(40, 9);
			else
				len = $urandom_range(300, 41);
			send_message(LEN_W'(len), len);
			sent += len + 2;
		end
	endtask

	task automatic drain_then_set(input int send_pct, input int recv_pct);
		in_valid <= 1'b0;
		do @(negedge clk); while (payload_due.size() != 0);
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		@(negedge clk);
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{payload_byte, first_of_message, last_of_message, empty_message,
				message_length};
			if (payload_due.size() == 0) begin
				flag_error($sformatf("result %h with none expected", got));
			end else begin
				want = payload_due.pop_front();
				if (got.payload_byte !== want.payload_byte)
					flag_error($sformatf("payload_byte %h, want %h",
						got.payload_byte, want.payload_byte));
				if (got.first_of_message !== want.first_of_message)
					flag_error($sformatf("first_of_message %b, want %b",
						got.first_of_message, want.first_of_message));
				if (got.last_of_message !== want.last_of_message)
					flag_error($sformatf("last_of_message %b, want %b",
						got.last_of_message, want.last_of_message));
				if (got.empty_message !== want.empty_message)
					flag_error($sformatf("empty_message %b, want %b",
						got.empty_message, want.empty_message));
				if (got.message_length !== want.message_length)
					flag_error($sformatf("message_length %h, want %h",
						got.message_length, want.message_length));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int row = 0; row < DIRECTED_ROWS; row++)
			send_word(DIRECTED[row].word, DIRECTED[row].kind, DIRECTED[row].want);
		run_traffic(300);
		drain_then_set(55, 33);
		run_traffic(300);
		drain_then_set(0, 0);
		run_traffic(300);
		send_message(16'hFFFF, 20);
		drain_then_set(0, 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0 && payload_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

FILE: files.f
+incdir+rtl
rtl/lpd_pkg.sv
rtl/length_prefix_deframer_unit.sv
tb/length_prefix_deframer_unit_test.sv
